// ===== rtl/core/fat_volume_layout_parser_core_assert.svh =====
// Assertion macros shared by the FAT volume layout parser modules.
`ifndef FAT_VOLUME_LAYOUT_PARSER_CORE_ASSERT_SVH
`define FAT_VOLUME_LAYOUT_PARSER_CORE_ASSERT_SVH

`ifndef SYNTH

// A condition that holds at every clock edge out of reset.
`define FVLP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fvlp assertion failed");

// A consequence that holds in the same cycle as its antecedent.
`define FVLP_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fvlp assertion failed");

// A consequence that holds in the cycle after its antecedent.
`define FVLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fvlp assertion failed");

`else

`define FVLP_ASSERT_ALWAYS(label, cond)
`define FVLP_ASSERT_IMPLIES(label, ante, cons)
`define FVLP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/fvlp_pkg.sv =====
// Types and constants shared by the FAT volume layout parser.
`timescale 1ns / 1ps

package fvlp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SIG   = 2'd1,
      STATUS_BAD_GEOM = 2'd2
   } status_type;

   typedef struct packed {
      logic       func;
      logic [7:0] byte_value;
      logic [8:0] byte_index;
      logic       sector_end;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        is_fat32;
      logic [31:0] partition_start;
      logic [31:0] fat_start;
      logic [31:0] data_start;
      logic [31:0] root_start;
      logic [15:0] root_entries;
      logic [7:0]  cluster_sectors;
      logic [31:0] fat_sectors;
      logic [39:0] fat_entry_count;
   } rsp_type;

   // One classified sector, handed from the capture side to the layout side.
   typedef struct packed {
      logic        layout_en;
      status_type  status;
      logic        is_fat32;
      logic [31:0] volume_start;
      logic [15:0] reserved_count;
      logic [31:0] fat_size;
      logic [7:0]  per_cluster;
      logic [31:0] root_cluster_m2;
      logic [15:0] root_count_raw;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ===== rtl/core/fvlp_front.sv =====
// Byte capture and sector classification for the FAT volume layout parser.
`timescale 1ns / 1ps

module fvlp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fvlp_pkg::req_type req_data,
   input  fvlp_pkg::queue_stat_type q_stat,
   output logic              push,
   output fvlp_pkg::job_type push_job
);

   localparam logic [8:0] OFS_SECTOR_SIZE_HIGH = 9'h00C;
   localparam logic [8:0] OFS_PER_CLUSTER      = 9'h00D;
   localparam logic [8:0] OFS_RESERVED_LO      = 9'h00E;
   localparam logic [8:0] OFS_RESERVED_HI      = 9'h00F;
   localparam logic [8:0] OFS_COPIES           = 9'h010;
   localparam logic [8:0] OFS_ROOT_COUNT_LO    = 9'h011;
   localparam logic [8:0] OFS_ROOT_COUNT_HI    = 9'h012;
   localparam logic [8:0] OFS_FAT_SHORT_LO     = 9'h016;
   localparam logic [8:0] OFS_FAT_SHORT_HI     = 9'h017;
   localparam logic [8:0] OFS_FAT_LONG_0       = 9'h024;
   localparam logic [8:0] OFS_FAT_LONG_1       = 9'h025;
   localparam logic [8:0] OFS_FAT_LONG_2       = 9'h026;
   localparam logic [8:0] OFS_FAT_LONG_3       = 9'h027;
   localparam logic [8:0] OFS_ROOT_CLUS_0      = 9'h02C;
   localparam logic [8:0] OFS_ROOT_CLUS_1      = 9'h02D;
   localparam logic [8:0] OFS_ROOT_CLUS_2      = 9'h02E;
   localparam logic [8:0] OFS_ROOT_CLUS_3      = 9'h02F;
   localparam logic [8:0] OFS_TYPE_CODE        = 9'h1C2;
   localparam logic [8:0] OFS_TABLE_START_0    = 9'h1C6;
   localparam logic [8:0] OFS_TABLE_START_1    = 9'h1C7;
   localparam logic [8:0] OFS_TABLE_START_2    = 9'h1C8;
   localparam logic [8:0] OFS_TABLE_START_3    = 9'h1C9;
   localparam logic [8:0] OFS_SIG_LOW          = 9'h1FE;
   localparam logic [8:0] OFS_SIG_HIGH         = 9'h1FF;

   localparam logic [7:0] SIG_LOW_VALUE   = 8'h55;
   localparam logic [7:0] SIG_HIGH_VALUE  = 8'hAA;
   localparam logic [7:0] SECTOR_SIZE_512 = 8'h02;
   localparam logic [7:0] FAT_COPIES      = 8'h02;
   localparam logic [7:0] PT_EXTENDED     = 8'h05;
   localparam logic [7:0] PT_FAT16        = 8'h06;
   localparam logic [7:0] PT_FAT32        = 8'h0B;
   localparam logic [7:0] PT_FAT32_LBA    = 8'h0C;
   localparam logic [7:0] PT_FAT16_LBA    = 8'h0E;
   localparam logic [7:0] PT_EXT_LBA      = 8'h0F;

   logic [31:0] volume_start_ff, volume_start_in;
   logic [7:0]  sig_low_ff, sig_low_in;
   logic [7:0]  sig_high_ff, sig_high_in;
   logic [7:0]  type_code_ff, type_code_in;
   logic [31:0] table_start_ff, table_start_in;
   logic [7:0]  sector_size_high_ff, sector_size_high_in;
   logic [7:0]  per_cluster_ff, per_cluster_in;
   logic [15:0] reserved_count_ff, reserved_count_in;
   logic [7:0]  copies_ff, copies_in;
   logic [15:0] root_count_ff, root_count_in;
   logic [15:0] fat_short_ff, fat_short_in;
   logic [31:0] fat_long_ff, fat_long_in;
   logic [31:0] root_cluster_ff, root_cluster_in;

   logic              accept;
   logic              sig_ok;
   logic              is_fat32;
   fvlp_pkg::status_type status;
   logic [31:0]       mbr_start;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      sig_low_in          = sig_low_ff;
      sig_high_in         = sig_high_ff;
      type_code_in        = type_code_ff;
      table_start_in      = table_start_ff;
      sector_size_high_in = sector_size_high_ff;
      per_cluster_in      = per_cluster_ff;
      reserved_count_in   = reserved_count_ff;
      copies_in           = copies_ff;
      root_count_in       = root_count_ff;
      fat_short_in        = fat_short_ff;
      fat_long_in         = fat_long_ff;
      root_cluster_in     = root_cluster_ff;
      if (accept) begin
         case (req_data.byte_index)
            OFS_SECTOR_SIZE_HIGH: sector_size_high_in      = req_data.byte_value;
            OFS_PER_CLUSTER:      per_cluster_in           = req_data.byte_value;
            OFS_RESERVED_LO:      reserved_count_in[7:0]   = req_data.byte_value;
            OFS_RESERVED_HI:      reserved_count_in[15:8]  = req_data.byte_value;
            OFS_COPIES:           copies_in                = req_data.byte_value;
            OFS_ROOT_COUNT_LO:    root_count_in[7:0]       = req_data.byte_value;
            OFS_ROOT_COUNT_HI:    root_count_in[15:8]      = req_data.byte_value;
            OFS_FAT_SHORT_LO:     fat_short_in[7:0]        = req_data.byte_value;
            OFS_FAT_SHORT_HI:     fat_short_in[15:8]       = req_data.byte_value;
            OFS_FAT_LONG_0:       fat_long_in[7:0]         = req_data.byte_value;
            OFS_FAT_LONG_1:       fat_long_in[15:8]        = req_data.byte_value;
            OFS_FAT_LONG_2:       fat_long_in[23:16]       = req_data.byte_value;
            OFS_FAT_LONG_3:       fat_long_in[31:24]       = req_data.byte_value;
            OFS_ROOT_CLUS_0:      root_cluster_in[7:0]     = req_data.byte_value;
            OFS_ROOT_CLUS_1:      root_cluster_in[15:8]    = req_data.byte_value;
            OFS_ROOT_CLUS_2:      root_cluster_in[23:16]   = req_data.byte_value;
            OFS_ROOT_CLUS_3:      root_cluster_in[31:24]   = req_data.byte_value;
            OFS_TYPE_CODE:        type_code_in             = req_data.byte_value;
            OFS_TABLE_START_0:    table_start_in[7:0]      = req_data.byte_value;
            OFS_TABLE_START_1:    table_start_in[15:8]     = req_data.byte_value;
            OFS_TABLE_START_2:    table_start_in[23:16]    = req_data.byte_value;
            OFS_TABLE_START_3:    table_start_in[31:24]    = req_data.byte_value;
            OFS_SIG_LOW:          sig_low_in               = req_data.byte_value;
            OFS_SIG_HIGH:         sig_high_in              = req_data.byte_value;
            default: ;
         endcase
      end
   end

   // Classification sees the captures including the sector's last byte.
   always_comb begin
      sig_ok   = (sig_low_in == SIG_LOW_VALUE) && (sig_high_in == SIG_HIGH_VALUE);
      is_fat32 = (fat_short_in == 16'd0);
      if (type_code_in inside {PT_EXTENDED, PT_FAT16, PT_FAT32,
                               PT_FAT32_LBA, PT_FAT16_LBA, PT_EXT_LBA}) begin
         mbr_start = table_start_in;
      end else begin
         mbr_start = 32'd0;
      end

      volume_start_in = volume_start_ff;
      if (!req_data.func) begin
         status = sig_ok ? fvlp_pkg::STATUS_OK : fvlp_pkg::STATUS_NO_SIG;
         if (accept && req_data.sector_end && sig_ok) begin
            volume_start_in = mbr_start;
         end
      end else if (sector_size_high_in != SECTOR_SIZE_512) begin
         status = fvlp_pkg::STATUS_BAD_GEOM;
      end else if (!sig_ok) begin
         status = fvlp_pkg::STATUS_NO_SIG;
      end else if (copies_in != FAT_COPIES) begin
         status = fvlp_pkg::STATUS_BAD_GEOM;
      end else begin
         status = fvlp_pkg::STATUS_OK;
      end

      push                     = accept && req_data.sector_end;
      push_job.layout_en       = req_data.func && (status == fvlp_pkg::STATUS_OK);
      push_job.status          = status;
      push_job.is_fat32        = is_fat32;
      push_job.volume_start    = volume_start_in;
      push_job.reserved_count  = reserved_count_in;
      push_job.fat_size        = is_fat32 ? fat_long_in : {16'd0, fat_short_in};
      push_job.per_cluster     = per_cluster_in;
      push_job.root_cluster_m2 = root_cluster_in - 32'd2;
      push_job.root_count_raw  = root_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_start_ff     <= '1;
         sig_low_ff          <= '0;
         sig_high_ff         <= '0;
         type_code_ff        <= '0;
         table_start_ff      <= '0;
         sector_size_high_ff <= '0;
         per_cluster_ff      <= '0;
         reserved_count_ff   <= '0;
         copies_ff           <= '0;
         root_count_ff       <= '0;
         fat_short_ff        <= '0;
         fat_long_ff         <= '0;
         root_cluster_ff     <= '0;
      end else begin
         volume_start_ff     <= volume_start_in;
         sig_low_ff          <= sig_low_in;
         sig_high_ff         <= sig_high_in;
         type_code_ff        <= type_code_in;
         table_start_ff      <= table_start_in;
         sector_size_high_ff <= sector_size_high_in;
         per_cluster_ff      <= per_cluster_in;
         reserved_count_ff   <= reserved_count_in;
         copies_ff           <= copies_in;
         root_count_ff       <= root_count_in;
         fat_short_ff        <= fat_short_in;
         fat_long_ff         <= fat_long_in;
         root_cluster_ff     <= root_cluster_in;
      end
   end

endmodule

// ===== rtl/core/fvlp_queue.sv =====
// Short job queue between the capture side and the layout side.
`timescale 1ns / 1ps

`include "fat_volume_layout_parser_core_assert.svh"

module fvlp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fvlp_pkg::job_type         push_job,
   input  logic                      pop,
   output fvlp_pkg::job_type         head_job,
   output fvlp_pkg::queue_stat_type  q_stat
);

   localparam logic [fvlp_pkg::QUEUE_PTR_W-1:0] LAST_SLOT =
      fvlp_pkg::QUEUE_PTR_W'(fvlp_pkg::QUEUE_DEPTH - 1);
   localparam logic [fvlp_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
      fvlp_pkg::QUEUE_CNT_W'(fvlp_pkg::QUEUE_DEPTH);
   localparam logic [fvlp_pkg::QUEUE_PTR_W-1:0] PTR_STEP = fvlp_pkg::QUEUE_PTR_W'(1);
   localparam logic [fvlp_pkg::QUEUE_CNT_W-1:0] CNT_STEP = fvlp_pkg::QUEUE_CNT_W'(1);

   fvlp_pkg::job_type slot_ff [fvlp_pkg::QUEUE_DEPTH];

   logic [fvlp_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fvlp_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fvlp_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_STEP;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_STEP;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_STEP;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_STEP;
      end
   end

   assign head_job     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == FULL_COUNT);
   assign q_stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `FVLP_ASSERT_ALWAYS(a_queue_count_bound, count_ff <= FULL_COUNT)
   `FVLP_ASSERT_NEXT(a_queue_push_lands, push && !pop, !q_stat.empty)

endmodule

// ===== rtl/core/fvlp_back.sv =====
// Layout arithmetic and result register for the FAT volume layout parser.
`timescale 1ns / 1ps

`include "fat_volume_layout_parser_core_assert.svh"

module fvlp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  fvlp_pkg::job_type        head_job,
   input  fvlp_pkg::queue_stat_type q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fvlp_pkg::rsp_type        rsp_data
);

   // Stage A: sums and the root cluster product.
   logic        a_valid_ff, a_valid_in;
   logic        a_layout_en_ff;
   fvlp_pkg::status_type a_status_ff;
   logic        a_is_fat32_ff;
   logic [31:0] a_volume_start_ff;
   logic [31:0] a_fat1_ff, a_fat1_in;
   logic [31:0] a_base_ff, a_base_in;
   logic [31:0] a_prod_ff, a_prod_in;
   logic [31:0] a_fat_size_ff;
   logic [7:0]  a_per_cluster_ff;
   logic [15:0] a_root_count_ff;

   logic              out_valid_ff, out_valid_in;
   fvlp_pkg::rsp_type out_data_ff, out_data_in;

   logic a_move;
   logic [31:0] b_offset;

   assign a_move     = a_valid_ff && (!out_valid_ff || !rsp_stall);
   assign pop        = !q_stat.empty && (!a_valid_ff || a_move);
   assign a_valid_in = pop || (a_valid_ff && !a_move);

   assign a_fat1_in = head_job.volume_start + {16'd0, head_job.reserved_count};
   assign a_base_in = head_job.volume_start + {16'd0, head_job.reserved_count}
                      + {head_job.fat_size[30:0], 1'b0};
   assign a_prod_in = head_job.root_cluster_m2 * {24'd0, head_job.per_cluster};

   always_ff @(posedge clock) begin
      if (pop) begin
         a_layout_en_ff    <= head_job.layout_en;
         a_status_ff       <= head_job.status;
         a_is_fat32_ff     <= head_job.is_fat32;
         a_volume_start_ff <= head_job.volume_start;
         a_fat1_ff         <= a_fat1_in;
         a_base_ff         <= a_base_in;
         a_prod_ff         <= a_prod_in;
         a_fat_size_ff     <= head_job.fat_size;
         a_per_cluster_ff  <= head_job.per_cluster;
         a_root_count_ff   <= head_job.root_count_raw;
      end
   end

   // Stage B: one add selects the root or data offset, then the result beat.
   assign b_offset = a_is_fat32_ff ? a_prod_ff : {20'd0, a_root_count_ff[15:4]};

   always_comb begin
      out_data_in                 = '0;
      out_data_in.status          = a_status_ff;
      out_data_in.partition_start = a_volume_start_ff;
      if (a_layout_en_ff) begin
         out_data_in.is_fat32        = a_is_fat32_ff;
         out_data_in.fat_start       = a_fat1_ff;
         out_data_in.cluster_sectors = a_per_cluster_ff;
         out_data_in.fat_sectors     = a_fat_size_ff;
         if (a_is_fat32_ff) begin
            out_data_in.data_start      = a_base_ff;
            out_data_in.root_start      = a_base_ff + b_offset;
            out_data_in.root_entries    = {4'd0, a_per_cluster_ff, 4'd0};
            out_data_in.fat_entry_count = {1'b0, a_fat_size_ff, 7'd0};
         end else begin
            out_data_in.data_start      = a_base_ff + b_offset;
            out_data_in.root_start      = a_base_ff;
            out_data_in.root_entries    = a_root_count_ff;
            out_data_in.fat_entry_count = {16'd0, a_fat_size_ff[15:0], 8'd0};
         end
      end
   end

   assign out_valid_in = a_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (a_move) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `FVLP_ASSERT_NEXT(a_stage_a_holds, a_valid_ff && !a_move, a_valid_ff)
   `FVLP_ASSERT_IMPLIES(a_failed_has_no_layout,
      out_valid_ff && (out_data_ff.status != fvlp_pkg::STATUS_OK),
      (out_data_ff.fat_start == 32'd0) && !out_data_ff.is_fat32)

endmodule

// ===== rtl/core/fat_volume_layout_parser_core.sv =====
// Top level of the FAT16/FAT32 volume layout parser.
`timescale 1ns / 1ps

// The parser takes one sector byte per beat on the req_ channel, tagged with
// its index and with the sector role (master boot record or volume boot
// sector), and it takes a byte in every cycle as long as req_stall is low.
// Bytes at the positions of interest are latched as they pass. The beat that
// carries sector_end closes the sector: it produces exactly one rsp_ beat with
// the status and, for a good boot sector, the FAT start, data start, root
// start, root entry count and FAT size; other beats produce nothing. A result
// passes from the closing byte through a queue slot, the first layout stage
// and the result register. The capture side classifies each closed sector and
// places it in a four-entry job queue; the layout side pops jobs through a
// two-stage path, with the 32 by 8 root cluster product in its first stage and
// the final address add in its second, ending in the result register. The
// capture side stalls only when that queue is full, so bytes keep flowing
// while a result waits to be taken, and a steady one byte per cycle is
// sustained while the queue has room. The volume start found in a boot record
// carries over to later boot sectors and reads as all ones after reset.

module fat_volume_layout_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fvlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fvlp_pkg::rsp_type rsp_data
);

   logic                     push;
   logic                     pop;
   fvlp_pkg::job_type        push_job;
   fvlp_pkg::job_type        head_job;
   fvlp_pkg::queue_stat_type q_stat;

   // Capture and classification of the incoming sector bytes.
   fvlp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_job  (push_job)
   );

   // Decouples sector close from result delivery.
   fvlp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   // Layout arithmetic and the result register.
   fvlp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
